### sv/npr_pkg.sv
// Shared types for the next-prime search block: sequencer states and remainder unit status.
`default_nettype none

package npr_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAND,
        S_TEST,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_stat;

endpackage

`default_nettype wire

### sv/npr_rem_unit.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`default_nettype none

module npr_rem_unit
    import npr_pkg::*;
#(
    parameter int VALUE_BITS = 31
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [VALUE_BITS-1:0] i_dividend,
    input  wire logic [VALUE_BITS-1:0] i_divisor,
    output t_rem_stat                  o_stat
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(VALUE_BITS);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [VALUE_BITS-1:0] r_rem;
    logic [VALUE_BITS-1:0] r_dvd;
    logic [VALUE_BITS-1:0] r_dvs;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_done;

    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   diff;
    logic                  fits;

    assign trial = {r_rem, r_dvd[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_LOAD;
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - CNT_ONE;
            r_done <= (r_cnt == CNT_ONE);
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            // remainder always stays below the divisor, so the top bit drops
            r_rem <= fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
            r_dvd <= {r_dvd[VALUE_BITS-2:0], 1'b0};
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.zero = (r_rem == '0);

endmodule

`default_nettype wire

### sv/next_prime_in_range.sv
// Top level: sequencer that walks candidates and divisors over the shared remainder unit.
//
// Usage: drive i_range_start / i_range_end and raise start while busy is low; the item
// is taken on that edge and busy stays high until the result has been shown.
// Candidates run from range_start + 1 up to range_end inclusive; the first one with no
// divisor d, 2 <= d with d*d <= candidate, is returned with o_found set. An empty range
// or a range without such a candidate gives o_found = 0 and o_prime_value = 0.
// The result sits on o_found / o_prime_value, flagged by o_valid for exactly one cycle.
// There is no back-pressure: the receiver must take it in that cycle.
// Steps: S_CAND checks the candidate against range_end and resets d to 2; S_TEST
// checks d*d > candidate and otherwise starts a trial division in the bit-serial
// remainder unit; S_DIV waits for it, then tries the next d, or the next candidate
// if d divides it. S_DONE shows the result, and a new item can be taken in the cycle
// after the result. d*d is tracked by adding 2d+1, so no multiplier.
// Reset (synchronous, active low) returns the sequencer to idle and drops any item.
`default_nettype none

module next_prime_in_range
    import npr_pkg::*;
#(
    parameter int VALUE_BITS = 31
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    input  wire logic [VALUE_BITS-1:0] i_range_start,
    input  wire logic [VALUE_BITS-1:0] i_range_end,
    output logic                       busy,
    output logic                       o_valid,
    output logic                       o_found,
    output logic [VALUE_BITS-1:0]      o_prime_value
);

    localparam logic [VALUE_BITS:0]   ONE_W = (VALUE_BITS+1)'(1);
    localparam logic [VALUE_BITS-1:0] D_INIT = VALUE_BITS'(2);
    localparam logic [VALUE_BITS:0]   DSQ_INIT = (VALUE_BITS+1)'(4);

    t_state r_state;
    t_state n_state;

    logic [VALUE_BITS:0]   r_cand;
    logic [VALUE_BITS-1:0] r_hi;
    logic [VALUE_BITS-1:0] r_d;
    logic [VALUE_BITS:0]   r_dsq;
    logic                  r_found;
    logic [VALUE_BITS-1:0] r_prime;

    logic      accept;
    logic      past_end;
    logic      dsq_over;
    logic      div_start;
    t_rem_stat rem_stat;

    assign accept   = start && (r_state == S_IDLE);
    assign past_end = (r_cand > {1'b0, r_hi});
    assign dsq_over = (r_dsq > r_cand);

    npr_rem_unit #(
        .VALUE_BITS(VALUE_BITS)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_cand[VALUE_BITS-1:0]),
        .i_divisor  (r_d),
        .o_stat     (rem_stat)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start) n_state = S_CAND;
            S_CAND: n_state = past_end ? S_DONE : S_TEST;
            S_TEST: n_state = dsq_over ? S_DONE : S_DIV;
            S_DIV: begin
                if (rem_stat.done) begin
                    n_state = rem_stat.zero ? S_CAND : S_TEST;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy      = 1'b1;
        o_valid   = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: busy = 1'b0;
            S_TEST: div_start = !dsq_over;
            S_DONE: o_valid = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cand  <= {1'b0, i_range_start} + ONE_W;
            r_hi    <= i_range_end;
            r_found <= 1'b0;
            r_prime <= '0;
        end
        case (r_state)
            S_CAND: begin
                r_d   <= D_INIT;
                r_dsq <= DSQ_INIT;
            end
            S_TEST: begin
                if (dsq_over) begin
                    r_found <= 1'b1;
                    r_prime <= r_cand[VALUE_BITS-1:0];
                end
            end
            S_DIV: begin
                if (rem_stat.done) begin
                    if (rem_stat.zero) begin
                        r_cand <= r_cand + ONE_W;
                    end else begin
                        // (d+1)^2 = d^2 + 2d + 1
                        r_d   <= r_d + VALUE_BITS'(1);
                        r_dsq <= r_dsq + {r_d, 1'b1};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_found       = r_found;
    assign o_prime_value = r_prime;

endmodule

`default_nettype wire
